/* rtl/core/ppd_pkg.sv */
package ppd_pkg;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned TFracBits = 16;
  localparam int unsigned DistBits  = CoordBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic                        starts_polyline;
    logic                        ends_set;
  } in_item_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    logic                none_found;
  } out_item_t;

  // Command passed from front end to back end.
  typedef struct packed {
    logic                        do_seg;
    logic                        ends_set;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] qx;
    logic signed [CoordBits-1:0] qy;
  } seg_cmd_t;

endpackage

/* rtl/core/ppd_front.sv */
module ppd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ppd_pkg::in_item_t  in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output ppd_pkg::seg_cmd_t  cmd_o
);
  import ppd_pkg::*;

  logic                 have_prev_q;
  logic [CoordBits-1:0] prev_x_q, prev_y_q;
  logic                 cmd_valid_q;
  seg_cmd_t             cmd_q;
  logic                 take;

  assign in_ready_o  = !cmd_valid_q || cmd_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      cmd_valid_q <= 1'b0;
    end else begin
      if (cmd_valid_q && cmd_ready_i) cmd_valid_q <= 1'b0;
      if (take) begin
        cmd_valid_q <= 1'b1;
        prev_x_q    <= in_data_i.vertex_x;
        prev_y_q    <= in_data_i.vertex_y;
        have_prev_q <= !in_data_i.ends_set;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q.do_seg   <= have_prev_q && !in_data_i.starts_polyline;
      cmd_q.ends_set <= in_data_i.ends_set;
      cmd_q.ax       <= prev_x_q;
      cmd_q.ay       <= prev_y_q;
      cmd_q.bx       <= in_data_i.vertex_x;
      cmd_q.by       <= in_data_i.vertex_y;
      cmd_q.qx       <= in_data_i.query_x;
      cmd_q.qy       <= in_data_i.query_y;
    end
  end

endmodule

/* rtl/core/ppd_fifo.sv */
module ppd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  ppd_pkg::seg_cmd_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output ppd_pkg::seg_cmd_t rd_data_o
);
  import ppd_pkg::*;

  seg_cmd_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

/* rtl/core/ppd_back.sv */
module ppd_back #(
  parameter int unsigned CoordBitsP = ppd_pkg::CoordBits,
  parameter int unsigned TFracBitsP = ppd_pkg::TFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  ppd_pkg::seg_cmd_t  cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ppd_pkg::out_item_t out_data_o
);
  import ppd_pkg::*;

  localparam int unsigned DB = CoordBitsP + 1;      // differences
  localparam int unsigned PB = 2 * CoordBitsP + 3;  // squares, dot products
  localparam int unsigned TB = TFracBitsP + 1;
  localparam int unsigned SB = PB + 1;              // sqrt remainder width
  localparam int unsigned RB = (PB + 1) / 2;        // root width
  localparam int unsigned TCW = $clog2(TFracBitsP + 1);
  localparam int unsigned SCW = $clog2(RB + 1);
  localparam logic [PB-1:0] SqInf = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL1, S_MUL2, S_SUM, S_DIV, S_SCALE, S_SUB,
    S_SQ, S_ACC, S_SQRT, S_OUT
  } state_e;

  state_e state_q;
  seg_cmd_t cmd_q;
  logic signed [DB-1:0] ux_q, uy_q, wx_q, wy_q;
  logic signed [PB-1:0] p1_q, p2_q, num_q;
  logic [PB-1:0]        den_q, rem_q, best_q, mx2_q, my2_q;
  logic [TB-1:0]        t_q;
  logic [TCW-1:0]       tcnt_q;
  logic [DB-1:0]        sx_q, sy_q;
  logic signed [DB+1:0] dx_q, dy_q;
  logic [SB-1:0]        sr_q;
  logic [RB-1:0]        root_q;
  logic [SCW-1:0]       scnt_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic [PB:0]      rem_sh;
  logic [DB+TB-1:0] prx, pry;
  logic [DB-1:0]    amx, amy;
  logic [DB+1:0]    mdx, mdy;
  logic [PB-1:0]    sq_sum, new_best;

  assign cmd_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rem_sh  = {rem_q, 1'b0};
  assign amx     = ux_q[DB-1] ? DB'(-ux_q) : DB'(ux_q);
  assign amy     = uy_q[DB-1] ? DB'(-uy_q) : DB'(uy_q);
  assign prx     = (DB+TB)'(amx) * (DB+TB)'(t_q) + ((DB+TB)'(1) << (TFracBitsP - 1));
  assign pry     = (DB+TB)'(amy) * (DB+TB)'(t_q) + ((DB+TB)'(1) << (TFracBitsP - 1));
  assign mdx     = dx_q[DB+1] ? (DB+2)'(-dx_q) : (DB+2)'(dx_q);
  assign mdy     = dy_q[DB+1] ? (DB+2)'(-dy_q) : (DB+2)'(dy_q);
  assign sq_sum  = mx2_q + my2_q;
  assign new_best = (sq_sum == SqInf) ? SqInf - PB'(1) : sq_sum;

  // Square root: bit pair per cycle, restoring.
  logic [SB-1:0]   s_rem_sh, s_cand;
  logic [2*RB-1:0] s_src;
  assign s_src    = (2*RB)'(best_q);
  assign s_rem_sh = {sr_q[SB-3:0], s_src[2*scnt_q-1 -: 2]};
  assign s_cand   = SB'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      best_q      <= SqInf;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          cmd_q   <= cmd_i;
          state_q <= cmd_i.do_seg ? S_DIFF : (cmd_i.ends_set ? S_SQRT : S_IDLE);
          sr_q    <= '0;
          root_q  <= '0;
          scnt_q  <= SCW'(RB);
        end
        S_DIFF: begin
          ux_q <= DB'(cmd_q.bx) - DB'(cmd_q.ax);
          uy_q <= DB'(cmd_q.by) - DB'(cmd_q.ay);
          wx_q <= DB'(cmd_q.qx) - DB'(cmd_q.ax);
          wy_q <= DB'(cmd_q.qy) - DB'(cmd_q.ay);
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          p1_q <= PB'(wx_q * ux_q);
          p2_q <= PB'(wy_q * uy_q);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          num_q <= p1_q + p2_q;
          p1_q  <= PB'(ux_q * ux_q);
          p2_q  <= PB'(uy_q * uy_q);
          state_q <= S_SUM;
        end
        S_SUM: begin
          den_q  <= p1_q + p2_q;
          rem_q  <= num_q;
          t_q    <= '0;
          tcnt_q <= '0;
          if (num_q <= 0 || (p1_q + p2_q) == '0) begin
            state_q <= S_SCALE;
          end else if (num_q >= (p1_q + p2_q)) begin
            t_q     <= TB'(1) << TFracBitsP;
            state_q <= S_SCALE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= PB'(rem_sh - {1'b0, den_q});
            t_q   <= {t_q[TB-2:0], 1'b1};
          end else begin
            rem_q <= PB'(rem_sh);
            t_q   <= {t_q[TB-2:0], 1'b0};
          end
          tcnt_q <= tcnt_q + TCW'(1);
          if (tcnt_q == TCW'(TFracBitsP - 1)) state_q <= S_SCALE;
        end
        S_SCALE: begin
          sx_q <= DB'(prx >> TFracBitsP);
          sy_q <= DB'(pry >> TFracBitsP);
          state_q <= S_SUB;
        end
        S_SUB: begin
          dx_q <= (DB+2)'(wx_q) - (ux_q[DB-1] ? -(DB+2)'(sx_q) : (DB+2)'(sx_q));
          dy_q <= (DB+2)'(wy_q) - (uy_q[DB-1] ? -(DB+2)'(sy_q) : (DB+2)'(sy_q));
          state_q <= S_SQ;
        end
        S_SQ: begin
          mx2_q <= PB'(mdx * mdx);
          my2_q <= PB'(mdy * mdy);
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (new_best < best_q) best_q <= new_best;
          state_q <= cmd_q.ends_set ? S_SQRT : S_IDLE;
        end
        S_SQRT: begin
          if (best_q == SqInf) begin
            state_q <= S_OUT;
          end else begin
            if (s_rem_sh >= s_cand) begin
              sr_q   <= s_rem_sh - s_cand;
              root_q <= {root_q[RB-2:0], 1'b1};
            end else begin
              sr_q   <= s_rem_sh;
              root_q <= {root_q[RB-2:0], 1'b0};
            end
            scnt_q <= scnt_q - SCW'(1);
            if (scnt_q == SCW'(1)) state_q <= S_OUT;
          end
        end
        S_OUT: if (!out_valid_q || out_ready_i) begin
          if (best_q == SqInf) begin
            out_q.distance   <= '1;
            out_q.none_found <= 1'b1;
          end else begin
            out_q.distance   <= (root_q > RB'({DistBits{1'b1}})) ? '1
                                : DistBits'(root_q);
            out_q.none_found <= 1'b0;
          end
          out_valid_q <= 1'b1;
          best_q      <= SqInf;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_best_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || out_ready_i)) |=> best_q == SqInf)
    else $error("best not cleared");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < den_q)
    else $error("divider remainder");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> state_q == S_IDLE)
    else $error("ready outside idle");

endmodule

/* rtl/core/point_polyline_distance_unit.sv */
// Point-to-polyline distance, 2-D, Q12.12. Stream vertices with the query
// point; starts_polyline breaks the chain and ends_set closes a set and
// yields one result transaction (floor sqrt of the minimum squared distance,
// or all ones with none_found). A front end pairs each vertex with the last
// one and queues a segment command in a two-entry FIFO; the back end runs
// one segment at a time through setup and multiply steps and a restoring
// divider, with a final 2-bits-per-cycle square root on the end of a set.
module point_polyline_distance_unit #(
  parameter int unsigned COORD_BITS  = ppd_pkg::CoordBits,
  parameter int unsigned T_FRAC_BITS = ppd_pkg::TFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ppd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ppd_pkg::out_item_t out_data_o
);
  import ppd_pkg::*;

  logic     f_valid, f_ready, b_valid, b_ready;
  seg_cmd_t f_cmd, b_cmd;

  ppd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  ppd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_cmd)
  );

  ppd_back #(.CoordBitsP(COORD_BITS), .TFracBitsP(T_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

// Bench for point_polyline_distance_unit. Vertex sets are streamed in; a
// local model tracks the previous vertex and the running minimum square and
// predicts one result per set end. Results are matched in order.
module tb;
  import ppd_pkg::*;

  localparam int unsigned SqBits = 2 * CoordBits + 3;
  localparam longint unsigned SqInf = (64'd1 << SqBits) - 1;
  localparam longint unsigned DistMax = (64'd1 << DistBits) - 1;
  localparam longint CycleLimit = 2000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  point_polyline_distance_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Model state, mirrors the block's registers.
  longint          prev_x, prev_y;
  bit              have_prev;
  longint unsigned best_sq;
  out_item_t       pending_dist[$];
  int              errors;
  longint          cycles;
  bit              hold_off;   // long receiver stall request
  bit              random_rx;  // receiver gaps enabled

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // u * t with t in Q1.TFracBits, rounded half away from zero
  function automatic longint scale_t(longint u, longint unsigned t);
    longint unsigned p;
    p = (abs64(u) * t + (64'd1 << (TFracBits - 1))) >> TFracBits;
    return u < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned segment_square(longint ax, longint ay, longint bx,
                                                     longint by, longint qx, longint qy);
    longint ux, uy, wx, wy, num, dx, dy;
    longint unsigned den, t, r;
    ux = bx - ax;
    uy = by - ay;
    wx = qx - ax;
    wy = qy - ay;
    num = wx * ux + wy * uy;
    den = longint'(ux * ux) + longint'(uy * uy);
    t = 0;
    if (num <= 0 || den == 0) begin
      t = 0;
    end else if (longint'(num) >= den) begin
      t = 64'd1 << TFracBits;
    end else begin
      r = num;
      for (int i = 0; i < TFracBits; i++) begin
        r = r << 1;
        t = t << 1;
        if (r >= den) begin
          r = r - den;
          t = t | 1;
        end
      end
    end
    dx = wx - scale_t(ux, t);
    dy = wy - scale_t(uy, t);
    return abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Advance the model by one vertex; queue a result on set end.
  task automatic predict_vertex(in_item_t it);
    longint unsigned sq, d;
    out_item_t exp_item;
    if (have_prev && !it.starts_polyline) begin
      sq = segment_square(prev_x, prev_y, it.vertex_x, it.vertex_y, it.query_x, it.query_y);
      if (sq > SqInf - 1) sq = SqInf - 1;
      if (sq < best_sq) best_sq = sq;
    end
    prev_x = it.vertex_x;
    prev_y = it.vertex_y;
    have_prev = 1'b1;
    if (it.ends_set) begin
      if (best_sq == SqInf) begin
        exp_item.distance = DistBits'(DistMax);
        exp_item.none_found = 1'b1;
      end else begin
        d = int_sqrt(best_sq);
        exp_item.distance = DistBits'(d > DistMax ? DistMax : d);
        exp_item.none_found = 1'b0;
      end
      pending_dist.push_back(exp_item);
      best_sq = SqInf;
      have_prev = 1'b0;
    end
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  bit tx_gaps;

  // Offer one transaction, hold it until accepted, then update the model.
  // Valid drops only when a gap follows; back to back it stays high.
  task automatic send_vertex(in_item_t it);
    int g;
    g = tx_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_vertex(it);
  endtask

  function automatic logic signed [CoordBits-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CoordBits-1){1'b0}}};
      1: return {1'b0, {(CoordBits-1){1'b1}}};
      2: return CoordBits'($signed($urandom_range(0, 8191)) - 4096);
      default: return CoordBits'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_vertex(int qx, int qy, int vx, int vy,
                                           logic st, logic en);
    in_item_t it;
    it.query_x = CoordBits'(qx);
    it.query_y = CoordBits'(qy);
    it.vertex_x = CoordBits'(vx);
    it.vertex_y = CoordBits'(vy);
    it.starts_polyline = st;
    it.ends_set = en;
    return it;
  endfunction

  // Directed corners: empty set, zero-length segment, projection before a,
  // past b, interior, start flag breaking a chain, coordinate extremes.
  task automatic test_corners();
    logic signed [CoordBits-1:0] mx, mn;
    mx = {1'b0, {(CoordBits-1){1'b1}}};
    mn = {1'b1, {(CoordBits-1){1'b0}}};
    send_vertex(make_vertex(0, 0, 100, 100, 1'b1, 1'b1));          // lone vertex
    send_vertex(make_vertex(5, 7, 3, 3, 1'b1, 1'b0));              // zero length
    send_vertex(make_vertex(5, 7, 3, 3, 1'b0, 1'b1));
    send_vertex(make_vertex(-50, 0, 0, 0, 1'b0, 1'b0));            // before a
    send_vertex(make_vertex(-50, 0, 4096, 0, 1'b0, 1'b1));
    send_vertex(make_vertex(9000, 10, 0, 0, 1'b0, 1'b0));          // past b
    send_vertex(make_vertex(9000, 10, 4096, 0, 1'b0, 1'b1));
    send_vertex(make_vertex(1234, 777, 0, 0, 1'b1, 1'b0));         // interior
    send_vertex(make_vertex(1234, 777, 4096, 4000, 1'b0, 1'b0));
    send_vertex(make_vertex(1234, 777, 8000, -300, 1'b1, 1'b0));   // chain break
    send_vertex(make_vertex(1234, 777, -8000, 300, 1'b0, 1'b1));
    send_vertex(make_vertex(mx, mx, mn, mn, 1'b0, 1'b0));          // extremes
    send_vertex(make_vertex(mx, mx, mn, mx, 1'b0, 1'b1));
    send_vertex(make_vertex(mn, mn, mx, mx, 1'b0, 1'b0));
    send_vertex(make_vertex(mn, mn, mx, mx, 1'b0, 1'b1));          // zero length at far end
    send_vertex(make_vertex(mx, mn, mn, mx, 1'b1, 1'b0));
    send_vertex(make_vertex(mx, mn, mx, mn, 1'b0, 1'b1));
  endtask

  // Random sets; mostly well-formed polylines with random content.
  task automatic test_random_sets(int n_items);
    int sent, len;
    logic signed [CoordBits-1:0] qx, qy;
    sent = 0;
    while (sent < n_items) begin
      qx = rand_coord();
      qy = rand_coord();
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_vertex(make_vertex($urandom_range(0, 9) == 0 ? rand_coord() : qx,
                                qy, rand_coord(), rand_coord(),
                                (i == 0) ? 1'b1 : ($urandom_range(0, 5) == 0),
                                i == len - 1));
        sent++;
      end
    end
  endtask

  // Receiver stalls for a long stretch while sender keeps offering.
  task automatic test_backpressure();
    hold_off = 1'b1;
    tx_gaps = 1'b0;
    test_random_sets(40);
    tx_gaps = 1'b1;
    hold_off = 1'b0;
  endtask

  // Receiver: random ready, long holds on request.
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        n = 0;
        while (n < 3000) begin
          @(posedge clk);
          n++;
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (random_rx) begin
        n = gap_len();
        out_ready <= (n == 0);
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dist.size() == 0) begin
        $error("unexpected result distance=%0d none_found=%0b",
               out_data.distance, out_data.none_found);
        errors++;
      end else begin
        exp_item = pending_dist.pop_front();
        if (out_data.distance !== exp_item.distance) begin
          $error("distance: expected %0d actual %0d", exp_item.distance, out_data.distance);
          errors++;
        end
        if (out_data.none_found !== exp_item.none_found) begin
          $error("none_found: expected %0b actual %0b",
                 exp_item.none_found, out_data.none_found);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("point_polyline_distance_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int drain;
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    random_rx = 1'b0;
    tx_gaps = 1'b1;
    have_prev = 1'b0;
    prev_x = 0;
    prev_y = 0;
    best_sq = SqInf;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    random_rx = 1'b1;
    test_random_sets(180);
    test_backpressure();
    random_rx = 1'b0;
    tx_gaps = 1'b0;
    test_random_sets(60);
    random_rx = 1'b1;
    tx_gaps = 1'b1;
    test_random_sets(120);
    in_valid <= 1'b0;

    while (pending_dist.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 200) begin
      @(posedge clk);
      drain++;
    end
    if (errors == 0) begin
      $display("point_polyline_distance_unit: match");
    end else begin
      $display("point_polyline_distance_unit: mismatch");
    end
    $finish;
  end

endmodule
